### design/srs_pkg.sv
// srs_pkg: shared types for the systematic resampling index generator
// no dependencies; imported by srs_front, srs_back and the top level
`default_nettype none

package srs_pkg;

    localparam int CountBits = 7;
    localparam int IndexBits = 6;
    localparam int OffsetBits = 16;
    localparam int ApbDataBits = 32;
    localparam int ApbAddrBits = 3;

    localparam logic [ApbAddrBits-1:0] RegParticleCount = 3'd0;
    localparam logic [IndexBits-1:0] PositionMax = 6'd63;

    // control part of one queued request
    typedef struct packed {
        logic                 first;
        logic                 last;
        logic [IndexBits-1:0] pos;
        logic [CountBits-1:0] n;
    } srs_ctrl_t;

endpackage

`default_nettype wire

### design/systematic_resample_index.sv
// systematic_resample_index: top level of the resampling index generator
// depends on srs_pkg, srs_front, srs_queue and srs_back
//
// Weights enter one per cycle while the four-request queue has room; the
// front end scales each weight by N, accumulates it with saturation and
// queues the request. The back end emits one ancestor index per cycle, one
// per slot filled, unless out_stall holds a pending result; a request that
// fills no slot still occupies the back end before the next one is taken.
// Throughput is set by the back end's one-slot-per-cycle walk.
`default_nettype none

module systematic_resample_index
    import srs_pkg::*;
#(
    parameter int MAX_PARTICLES = 64,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [ApbAddrBits-1:0]    paddr,
    input  wire logic [ApbDataBits-1:0]    pwdata,
    output logic [ApbDataBits-1:0]         prdata,
    output logic                           pready,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [WEIGHT_FRAC_BITS:0] weight,
    input  wire logic [OffsetBits-1:0]     random_offset,
    input  wire logic                      first_weight,
    input  wire logic                      last_weight,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [IndexBits-1:0]           sample_index,
    output logic [IndexBits-1:0]           slot_index,
    output logic                           last_of_run,
    output logic                           set_complete
);

    localparam int SW = WEIGHT_FRAC_BITS + 8;
    localparam int QW = SW + WEIGHT_FRAC_BITS + $bits(srs_ctrl_t);

    logic                        q_push, q_full, q_pop, q_valid;
    logic [SW-1:0]               push_sum, pop_sum;
    logic [WEIGHT_FRAC_BITS-1:0] push_off, pop_off;
    srs_ctrl_t                   push_ctrl, pop_ctrl;
    logic [QW-1:0]               pop_data;

    assign pready = 1'b1;

    srs_front #(
        .MAX_PARTICLES(MAX_PARTICLES),
        .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .weight(weight),
        .random_offset(random_offset),
        .first_weight(first_weight),
        .last_weight(last_weight),
        .q_full(q_full),
        .q_push(q_push),
        .q_sum(push_sum),
        .q_off(push_off),
        .q_ctrl(push_ctrl)
    );

    srs_queue #(
        .WIDTH(QW),
        .DEPTH(4)
    ) u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(q_push),
        .push_data({push_sum, push_off, push_ctrl}),
        .full(q_full),
        .pop(q_pop),
        .not_empty(q_valid),
        .pop_data(pop_data)
    );

    assign {pop_sum, pop_off, pop_ctrl} = pop_data;

    srs_back #(
        .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .q_valid(q_valid),
        .q_sum(pop_sum),
        .q_off(pop_off),
        .q_ctrl(pop_ctrl),
        .q_pop(q_pop),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .sample_index(sample_index),
        .slot_index(slot_index),
        .last_of_run(last_of_run),
        .set_complete(set_complete)
    );

endmodule

`default_nettype wire

### design/srs_queue.sv
// srs_queue: small register fifo between front and back end
// no dependencies
`default_nettype none

module srs_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntBits = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]   mem_reg [DEPTH];
    logic [PtrBits-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrBits-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntBits-1:0] count_reg, count_next;
    logic               do_push, do_pop;

    assign full      = (count_reg == CntBits'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### design/srs_front.sv
// srs_front: particle count register, weight accumulation and request build
// depends on srs_pkg; feeds srs_queue
`default_nettype none

module srs_front
    import srs_pkg::*;
#(
    parameter int MAX_PARTICLES = 64,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ApbAddrBits-1:0]        paddr,
    input  wire logic [ApbDataBits-1:0]        pwdata,
    output logic [ApbDataBits-1:0]             prdata,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [WEIGHT_FRAC_BITS:0]     weight,
    input  wire logic [OffsetBits-1:0]         random_offset,
    input  wire logic                          first_weight,
    input  wire logic                          last_weight,
    input  wire logic                          q_full,
    output logic                               q_push,
    output logic [WEIGHT_FRAC_BITS+7:0]        q_sum,
    output logic [WEIGHT_FRAC_BITS-1:0]        q_off,
    output srs_ctrl_t                          q_ctrl
);

    localparam int SW = WEIGHT_FRAC_BITS + 8;
    localparam logic [CountBits-1:0] MaxCount = CountBits'(MAX_PARTICLES);

    logic [CountBits-1:0]  count_reg;
    logic [SW-1:0]         sum_reg, sum_next;
    logic [OffsetBits-1:0] off_reg, off_next;
    logic [IndexBits-1:0]  pos_reg, pos_cur, pos_next;
    logic [CountBits-1:0]  n_eff;
    logic [SW-1:0]         prod, base;
    logic [SW:0]           total;
    logic                  accept;

    assign accept   = in_valid && !q_full;
    assign in_stall = q_full;
    assign prdata   = {{(ApbDataBits-CountBits){1'b0}}, count_reg};

    always_comb
    begin
        priority if (count_reg == '0)
        begin
            n_eff = CountBits'(1);
        end
        else if (count_reg > MaxCount)
        begin
            n_eff = MaxCount;
        end
        else
        begin
            n_eff = count_reg;
        end
    end

    assign base     = first_weight ? '0 : sum_reg;
    assign prod     = {{(SW-CountBits){1'b0}}, n_eff} * {7'd0, weight};
    assign total    = {1'b0, base} + {1'b0, prod};
    assign sum_next = total[SW] ? '1 : total[SW-1:0];
    assign off_next = first_weight ? random_offset : off_reg;
    assign pos_cur  = first_weight ? '0 : pos_reg;
    assign pos_next = (pos_cur < PositionMax) ? pos_cur + 1'b1 : pos_cur;

    generate
        if (WEIGHT_FRAC_BITS >= OffsetBits)
        begin : g_off_up
            assign q_off = WEIGHT_FRAC_BITS'(off_next) << (WEIGHT_FRAC_BITS - OffsetBits);
        end
        else
        begin : g_off_down
            assign q_off = off_next[OffsetBits-1 -: WEIGHT_FRAC_BITS];
        end
    endgenerate

    assign q_push       = accept;
    assign q_sum        = sum_next;
    assign q_ctrl.first = first_weight;
    assign q_ctrl.last  = last_weight;
    assign q_ctrl.pos   = pos_cur;
    assign q_ctrl.n     = n_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= MaxCount;
            sum_reg   <= '0;
            off_reg   <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            if (psel && penable && pwrite && (paddr[2] == RegParticleCount[2]))
            begin
                count_reg <= pwdata[CountBits-1:0];
            end
            if (accept)
            begin
                sum_reg <= sum_next;
                off_reg <= off_next;
                pos_reg <= pos_next;
            end
        end
    end

endmodule

`default_nettype wire

### design/srs_back.sv
// srs_back: walks the slots of one request and emits one index per cycle unless out_stall holds a pending result
// depends on srs_pkg; reads from srs_queue
`default_nettype none

module srs_back
    import srs_pkg::*;
#(
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    input  wire logic [WEIGHT_FRAC_BITS+7:0]   q_sum,
    input  wire logic [WEIGHT_FRAC_BITS-1:0]   q_off,
    input  wire srs_ctrl_t                     q_ctrl,
    output logic                               q_pop,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [IndexBits-1:0]               sample_index,
    output logic [IndexBits-1:0]               slot_index,
    output logic                               last_of_run,
    output logic                               set_complete
);

    localparam int SW = WEIGHT_FRAC_BITS + 8;

    logic                        active_reg, active_next;
    logic [SW-1:0]               sum_reg;
    logic [WEIGHT_FRAC_BITS-1:0] off_reg;
    srs_ctrl_t                   ctrl_reg;
    logic [CountBits-1:0]        slots_reg, slots_next;
    logic                        out_valid_reg, out_valid_next;
    logic [IndexBits-1:0]        sample_reg, slot_reg;
    logic                        last_reg, done_reg;

    logic [CountBits-1:0] slots_inc;
    logic                 gt0, gt1, c0, c1, can_out, emit, finish;

    assign slots_inc = slots_reg + 1'b1;
    assign gt0 = sum_reg > {1'b0, slots_reg, off_reg};
    assign gt1 = sum_reg > {1'b0, slots_inc, off_reg};
    assign c0  = active_reg && (slots_reg < ctrl_reg.n) && (ctrl_reg.last || gt0);
    assign c1  = (slots_inc < ctrl_reg.n) && (ctrl_reg.last || gt1);

    assign can_out = !out_valid_reg || !out_stall;
    assign emit    = c0 && can_out;
    assign finish  = active_reg && (!c0 || (emit && !c1));
    assign q_pop   = q_valid && (!active_reg || finish);

    always_comb
    begin
        active_next = active_reg;
        slots_next  = emit ? slots_inc : slots_reg;
        if (q_pop)
        begin
            active_next = 1'b1;
            if (q_ctrl.first)
            begin
                slots_next = '0;
            end
        end
        else if (finish)
        begin
            active_next = 1'b0;
        end
        out_valid_next = emit ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            slots_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            slots_reg     <= slots_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            sum_reg  <= q_sum;
            off_reg  <= q_off;
            ctrl_reg <= q_ctrl;
        end
        if (emit)
        begin
            sample_reg <= gt0 ? ctrl_reg.pos : '0;
            slot_reg   <= slots_reg[IndexBits-1:0];
            last_reg   <= !c1;
            done_reg   <= (slots_inc == ctrl_reg.n);
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample_index = sample_reg;
    assign slot_index   = slot_reg;
    assign last_of_run  = last_reg;
    assign set_complete = done_reg;

endmodule

`default_nettype wire

### design/srs_checker.sv
// srs_checker: port-level assertions for systematic_resample_index
// bound to the top level; no package dependency
`default_nettype none

module srs_checker #(
    parameter int MAX_PARTICLES = 64
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic [31:0] prdata,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [5:0]  sample_index,
    input wire logic [5:0]  slot_index,
    input wire logic        last_of_run,
    input wire logic        set_complete
);

    localparam logic [6:0] MaxCount = 7'(MAX_PARTICLES);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample_index)
            && $stable(slot_index) && $stable(last_of_run) && $stable(set_complete))
        else $error("stalled result changed");

    // filling the last slot always closes the run
    a_complete_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && set_complete |-> last_of_run)
        else $error("set complete without end of run");

    // last slot matches the configured count
    a_complete_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && set_complete && (prdata[6:0] != 7'd0) && (prdata[6:0] <= MaxCount)
            |-> ({1'b0, slot_index} == prdata[6:0] - 7'd1))
        else $error("set complete on wrong slot");

    // a run continues with the next slot in the next cycle
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_run
            |=> out_valid && (slot_index == $past(slot_index) + 6'd1))
        else $error("run broken");

endmodule

bind systematic_resample_index srs_checker #(
    .MAX_PARTICLES(MAX_PARTICLES)
) u_srs_checker (
    .clk(clk),
    .rst_n(rst_n),
    .prdata(prdata),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sample_index(sample_index),
    .slot_index(slot_index),
    .last_of_run(last_of_run),
    .set_complete(set_complete)
);

`default_nettype wire
